@@ rtl/core/brsp_pkg.sv @@
// Package for the bounded-repeat stack: state encoding, status codes,
// operation and register codes, field widths. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package brsp_pkg;

   localparam int DATA_W   = 32;
   localparam int LIMIT_W  = 7;
   localparam int FILL_W   = 7;
   localparam int STATUS_W = 3;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // operation field
   localparam logic OP_PUSH = 1'b0;
   localparam logic OP_POP  = 1'b1;

   // result status codes
   localparam logic [STATUS_W-1:0] STATUS_PUSHED   = 3'd0;
   localparam logic [STATUS_W-1:0] STATUS_REJECTED = 3'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 3'd2;
   localparam logic [STATUS_W-1:0] STATUS_POPPED   = 3'd3;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY    = 3'd4;

   // register index (paddr bit 2)
   localparam logic CSR_IDX_MAX_REPEATS = 1'b0;
   localparam logic [LIMIT_W-1:0] MAX_REPEATS_RESET = 7'd1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE,
      ST_POP_RD,
      ST_POP_FIN
   } state_type;

endpackage

`default_nettype wire

@@ rtl/core/bounded_repeat_stack_push_top.sv @@
// Bounded-repeat stack, top level: sequencer, scan compare, APB register.
// Depends on brsp_pkg and brsp_ram.
//
// Usage:
//  - req channel (valid/ready) carries one item: operation (0 push, 1 pop)
//    and a signed 32-bit value. req_ready is high only while the sequencer
//    is idle; one item is in work at a time.
//  - rsp channel (valid/ready) returns exactly one item per request:
//    status, data_out (popped value, else zero) and fill_level after the item.
//  - A push scans the stack from the top, one entry per cycle through the
//    single read port of the stack RAM, counting matches against the value.
//    The scan stops once the count reaches max_repeats or the bottom is hit.
//    After the scan a decide state loads the status and fill into the output
//    register; the push holds the block until then.
//  - A pop goes through accept, RAM read and result; a pop on an empty
//    stack skips the RAM read.
//  - The result sits in an output register; a new item may be accepted while
//    it waits. If the receiver stalls, the next result holds in the final
//    sequencer state until the output register frees up.
//  - max_repeats is written over the APB port at byte address 0 (reset 1).
//  - Reset (synchronous, active high) empties the stack and returns to idle;
//    stack RAM contents are not cleared, no entry above the fill is read.
`timescale 1ns / 1ps
`default_nettype none

module bounded_repeat_stack_push_top #(
   parameter int STACK_DEPTH = 64
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   // request channel
   input  wire logic                                   req_valid,
   output logic                                        req_ready,
   input  wire logic                                   req_operation,
   input  wire logic signed [brsp_pkg::DATA_W-1:0]     req_value,
   // result channel
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic        [brsp_pkg::STATUS_W-1:0]        rsp_status,
   output logic signed [brsp_pkg::DATA_W-1:0]          rsp_data_out,
   output logic        [brsp_pkg::FILL_W-1:0]          rsp_fill_level,
   // configuration port
   input  wire logic                                   csr_psel,
   input  wire logic                                   csr_penable,
   input  wire logic                                   csr_pwrite,
   input  wire logic   [brsp_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  wire logic   [brsp_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic        [brsp_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                        csr_pready
);

   localparam int ADDR_W = $clog2(STACK_DEPTH);
   localparam int CNT_W  = $clog2(STACK_DEPTH + 1);

   // sequencer and stack state
   brsp_pkg::state_type                 state_ff, state_in;
   logic [CNT_W-1:0]                    count_ff, count_in;
   logic [CNT_W-1:0]                    pos_ff, pos_in;
   logic [brsp_pkg::LIMIT_W-1:0]        hits_ff, hits_in;
   logic                                rd_pend_ff, rd_pend_in;
   logic [brsp_pkg::DATA_W-1:0]         val_ff;
   logic [brsp_pkg::LIMIT_W-1:0]        max_repeats_ff;

   // output register
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [brsp_pkg::STATUS_W-1:0]       rsp_status_ff, rsp_status_in;
   logic [brsp_pkg::DATA_W-1:0]         rsp_data_ff, rsp_data_in;
   logic [brsp_pkg::FILL_W-1:0]         rsp_fill_ff, rsp_fill_in;
   logic                                rsp_load;

   // RAM port
   logic                                mem_we, mem_re;
   logic [ADDR_W-1:0]                   mem_waddr, mem_raddr;
   logic [brsp_pkg::DATA_W-1:0]         mem_rdata;

   // scan datapath
   logic [CNT_W-1:0]                    pos_m1;
   logic                                hit;
   logic [brsp_pkg::LIMIT_W-1:0]        hits_nxt;
   logic                                scan_go;
   logic                                out_free;
   logic                                csr_wr;

   brsp_ram #(
      .WIDTH (brsp_pkg::DATA_W),
      .DEPTH (STACK_DEPTH)
   ) u_stack (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (val_ff),
      .rd_en   (mem_re),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   // APB register: one register, index on paddr[2]
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == brsp_pkg::CSR_IDX_MAX_REPEATS);
   assign csr_prdata = (csr_paddr[2] == brsp_pkg::CSR_IDX_MAX_REPEATS)
                       ? brsp_pkg::CSR_DATA_W'(max_repeats_ff)
                       : '0;

   // handshake
   assign req_ready      = (state_ff == brsp_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_data_out   = rsp_data_ff;
   assign rsp_fill_level = rsp_fill_ff;
   assign out_free       = !rsp_valid_ff || rsp_ready;

   // compare the entry read last cycle, then decide whether to read another
   assign pos_m1   = pos_ff - 1'b1;
   assign hit      = rd_pend_ff && (mem_rdata == val_ff);
   assign hits_nxt = hits_ff + brsp_pkg::LIMIT_W'(hit);
   assign scan_go  = (pos_ff != '0) && (hits_nxt < max_repeats_ff);

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      hits_in       = hits_ff;
      rd_pend_in    = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_status_in = rsp_status_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_fill_in   = rsp_fill_ff;
      rsp_load      = 1'b0;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_waddr     = count_ff[ADDR_W-1:0];
      mem_raddr     = pos_m1[ADDR_W-1:0];

      case (state_ff)
         brsp_pkg::ST_IDLE: begin
            if (req_valid) begin
               pos_in  = count_ff;
               hits_in = '0;
               state_in = (req_operation == brsp_pkg::OP_POP) ? brsp_pkg::ST_POP_RD
                                                              : brsp_pkg::ST_SCAN;
            end
         end
         brsp_pkg::ST_SCAN: begin
            hits_in = hits_nxt;
            if (scan_go) begin
               mem_re     = 1'b1;
               pos_in     = pos_m1;
               rd_pend_in = 1'b1;
            end else begin
               state_in = brsp_pkg::ST_DECIDE;
            end
         end
         brsp_pkg::ST_DECIDE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               state_in = brsp_pkg::ST_IDLE;
               // limit check wins over the full check
               if (hits_ff >= max_repeats_ff) begin
                  rsp_status_in = brsp_pkg::STATUS_REJECTED;
               end else if (count_ff == CNT_W'(STACK_DEPTH)) begin
                  rsp_status_in = brsp_pkg::STATUS_FULL;
               end else begin
                  mem_we        = 1'b1;
                  count_in      = count_ff + 1'b1;
                  rsp_status_in = brsp_pkg::STATUS_PUSHED;
               end
               rsp_data_in  = '0;
               rsp_fill_in  = brsp_pkg::FILL_W'(count_in);
               rsp_valid_in = 1'b1;
            end
         end
         brsp_pkg::ST_POP_RD: begin
            if (count_ff == '0) begin
               if (out_free) begin
                  rsp_load      = 1'b1;
                  state_in      = brsp_pkg::ST_IDLE;
                  rsp_status_in = brsp_pkg::STATUS_EMPTY;
                  rsp_data_in   = '0;
                  rsp_fill_in   = '0;
                  rsp_valid_in  = 1'b1;
               end
            end else begin
               mem_re   = 1'b1;
               state_in = brsp_pkg::ST_POP_FIN;
            end
         end
         brsp_pkg::ST_POP_FIN: begin
            if (out_free) begin
               rsp_load      = 1'b1;
               state_in      = brsp_pkg::ST_IDLE;
               count_in      = count_ff - 1'b1;
               rsp_status_in = brsp_pkg::STATUS_POPPED;
               rsp_data_in   = mem_rdata;
               rsp_fill_in   = brsp_pkg::FILL_W'(count_in);
               rsp_valid_in  = 1'b1;
            end
         end
         default: begin
            state_in = brsp_pkg::ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= brsp_pkg::ST_IDLE;
         count_ff       <= '0;
         rd_pend_ff     <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         max_repeats_ff <= brsp_pkg::MAX_REPEATS_RESET;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr) begin
            max_repeats_ff <= csr_pwdata[brsp_pkg::LIMIT_W-1:0];
         end
      end
   end

   // payload
   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      hits_ff       <= hits_in;
      rsp_status_ff <= rsp_status_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_fill_ff   <= rsp_fill_in;
      if (req_valid && req_ready) begin
         val_ff <= req_value;
      end
   end

   // ---------------------------------------------------------------- checks

   // fill never exceeds the stack depth
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(STACK_DEPTH))
      else $error("stack count above depth");

   // a new result is only loaded when the output register is free
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      rsp_load |-> (!rsp_valid_ff || rsp_ready))
      else $error("result overwritten");

   // a pushed result grows the stack by exactly one entry
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      ($past(rsp_load) && !$past(reset) && rsp_status_ff == brsp_pkg::STATUS_PUSHED)
      |-> (count_ff == $past(count_ff) + 1'b1))
      else $error("push did not grow stack");

   // the match count never passes the limit during a scan
   a_hits_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == brsp_pkg::ST_SCAN) |-> (hits_ff <= max_repeats_ff))
      else $error("match count above limit");

endmodule

`default_nettype wire

@@ rtl/core/brsp_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

module brsp_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Testbench for bounded_repeat_stack_push_top: directed and random push/pop items,
// APB writes of the repeat limit, and a scoreboard that mirrors the stack.
// Depends on brsp_pkg and the RTL of the block.
`timescale 1ns / 1ps

module testbench;

   localparam int STACK_DEPTH = 64;
   localparam int STALL_LIMIT = 4000;  // cycles with no handshake at all
   localparam logic [brsp_pkg::CSR_ADDR_W-1:0] MAX_REPEATS_ADDR =
      {brsp_pkg::CSR_IDX_MAX_REPEATS, 2'b00};

   typedef struct packed {
      logic [brsp_pkg::STATUS_W-1:0]      status;
      logic signed [brsp_pkg::DATA_W-1:0] data;
      logic [brsp_pkg::FILL_W-1:0]        fill;
   } stack_outcome_type;

   // Mirror of the stack plus the queue of outcomes still owed by the block.
   class stack_tracker;
      logic signed [brsp_pkg::DATA_W-1:0] entries [STACK_DEPTH];
      int unsigned depth_used;
      int unsigned repeat_limit;
      stack_outcome_type pending_results[$];
      int unsigned mismatches;
      int unsigned tally [8];

      function new();
         depth_used = 0;
         repeat_limit = brsp_pkg::MAX_REPEATS_RESET;
         mismatches = 0;
         foreach (tally[i]) tally[i] = 0;
      endfunction

      function void set_limit(int unsigned lim);
         repeat_limit = lim & 7'h7F;
      endfunction

      // matches counted from the top, stopping once the limit is reached
      function int unsigned copies_from_top(logic signed [brsp_pkg::DATA_W-1:0] v);
         int unsigned hits;
         int unsigned pos;
         hits = 0;
         pos = depth_used;
         while (pos > 0 && hits < repeat_limit) begin
            pos--;
            if (entries[pos] == v) hits++;
         end
         return hits;
      endfunction

      function void note_request(logic op, logic signed [brsp_pkg::DATA_W-1:0] v);
         stack_outcome_type r;
         r.data = '0;
         if (op == brsp_pkg::OP_PUSH) begin
            // limit check wins over fullness
            if (copies_from_top(v) >= repeat_limit) begin
               r.status = brsp_pkg::STATUS_REJECTED;
            end else if (depth_used >= STACK_DEPTH) begin
               r.status = brsp_pkg::STATUS_FULL;
            end else begin
               entries[depth_used] = v;
               depth_used++;
               r.status = brsp_pkg::STATUS_PUSHED;
            end
         end else if (depth_used == 0) begin
            r.status = brsp_pkg::STATUS_EMPTY;
         end else begin
            depth_used--;
            r.data = entries[depth_used];
            r.status = brsp_pkg::STATUS_POPPED;
         end
         r.fill = brsp_pkg::FILL_W'(depth_used);
         pending_results.push_back(r);
      endfunction

      function void check_response(stack_outcome_type got);
         stack_outcome_type want;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected result status=%0d data=%0d fill=%0d",
                        $realtime, got.status, got.data, got.fill);
            return;
         end
         want = pending_results.pop_front();
         if (got.status !== want.status || got.data !== want.data ||
             got.fill !== want.fill) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: mismatch exp status=%0d data=%0d fill=%0d,",
                         " got status=%0d data=%0d fill=%0d"},
                        $realtime, want.status, want.data, want.fill,
                        got.status, got.data, got.fill);
         end else begin
            tally[got.status]++;
         end
      endfunction

      function int unsigned outstanding();
         return pending_results.size();
      endfunction
   endclass

   logic clock;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic req_operation = brsp_pkg::OP_PUSH;
   logic signed [brsp_pkg::DATA_W-1:0] req_value = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [brsp_pkg::STATUS_W-1:0] rsp_status;
   logic signed [brsp_pkg::DATA_W-1:0] rsp_data_out;
   logic [brsp_pkg::FILL_W-1:0] rsp_fill_level;
   logic csr_psel = 1'b0;
   logic csr_penable = 1'b0;
   logic csr_pwrite = 1'b0;
   logic [brsp_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [brsp_pkg::CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [brsp_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic csr_pready;

   stack_tracker tracker = new();
   stack_outcome_type observed;
   bit idle_enabled = 1'b1;     // cleared for one phase: back-to-back items
   int unsigned items_sent = 0;
   int unsigned settings_tried = 1;  // reset value counts as one setting
   int unsigned csr_mismatches = 0;
   int unsigned stalled_cycles = 0;

   bounded_repeat_stack_push_top #(.STACK_DEPTH(STACK_DEPTH)) uut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_value      (req_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_data_out   (rsp_data_out),
      .rsp_fill_level (rsp_fill_level),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // Result side: check on the handshake, then pick next cycle's ready.
   // Values read here are the ones present just before the edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         observed.status = rsp_status;
         observed.data   = rsp_data_out;
         observed.fill   = rsp_fill_level;
         tracker.check_response(observed);
      end
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !idle_enabled || ($urandom_range(99) >= 24);
   end

   // Watchdog: any handshake on any port counts as progress.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable)) begin
         stalled_cycles <= 0;
      end else if (stalled_cycles >= STALL_LIMIT) begin
         $display("watchdog: no handshake for %0d cycles, %0d results owed",
                  stalled_cycles, tracker.outstanding());
         $display("FAILED: results differ");
         $finish;
      end else begin
         stalled_cycles <= stalled_cycles + 1;
      end
   end

   // One item; may idle first. Valid stays up across back-to-back items.
   task automatic send_item(input logic op, input logic signed [brsp_pkg::DATA_W-1:0] v);
      if (idle_enabled && $urandom_range(99) < 24) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 24);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      req_value     <= v;
      do @(posedge clock); while (!req_ready);
      tracker.note_request(op, v);
      items_sent++;
   endtask

   // Sender holds off until every result is back, plus the worst scan time.
   task automatic wait_drained();
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (STACK_DEPTH + 4) @(posedge clock);
   endtask

   // APB write of max_repeats, then read it back.
   task automatic write_limit(input int unsigned lim);
      wait_drained();
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= MAX_REPEATS_ADDR;
      csr_pwdata  <= lim;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      tracker.set_limit(lim);
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== brsp_pkg::CSR_DATA_W'(lim & 7'h7F)) begin
         csr_mismatches++;
         $display("%0t: max_repeats readback exp %0d got %0d",
                  $realtime, lim & 7'h7F, csr_prdata);
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      settings_tried++;
   endtask

   // Random phase: pushes mostly draw from a small value pool so repeats
   // pile up; pops carry random (ignored) values.
   task automatic run_phase(input int unsigned lim, input int unsigned pool_size,
                            input int unsigned push_pct, input int unsigned count);
      logic signed [brsp_pkg::DATA_W-1:0] pool [$];
      logic signed [brsp_pkg::DATA_W-1:0] v;
      write_limit(lim);
      repeat (pool_size) pool.push_back($urandom());
      repeat (count) begin
         v = $urandom();
         if ($urandom_range(99) < push_pct) begin
            if ($urandom_range(9) != 0) v = pool[$urandom_range(pool_size - 1)];
            send_item(brsp_pkg::OP_PUSH, v);
         end else begin
            send_item(brsp_pkg::OP_POP, v);
         end
      end
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // --- directed, limit at its reset value of one ---
      send_item(brsp_pkg::OP_POP,  32'sh0);          // pop on empty
      send_item(brsp_pkg::OP_PUSH, 32'sh80000000);   // most negative
      send_item(brsp_pkg::OP_PUSH, 32'sh7FFFFFFF);   // most positive
      send_item(brsp_pkg::OP_PUSH, 32'sh0);
      send_item(brsp_pkg::OP_PUSH, -32'sd1);
      send_item(brsp_pkg::OP_PUSH, 32'sh80000000);   // already present: rejected
      send_item(brsp_pkg::OP_PUSH, 32'sh7FFFFFFF);   // match found deep in the stack
      send_item(brsp_pkg::OP_POP,  32'sh12345678);
      send_item(brsp_pkg::OP_POP,  32'shEDCBA987);
      send_item(brsp_pkg::OP_PUSH, 32'sh0);          // gone after pop, so admitted again
      send_item(brsp_pkg::OP_POP,  32'sh0);
      send_item(brsp_pkg::OP_POP,  32'sh0);
      send_item(brsp_pkg::OP_POP,  32'sh0);
      send_item(brsp_pkg::OP_POP,  32'sh0);          // empty again

      // zero limit: nothing may be pushed
      write_limit(0);
      send_item(brsp_pkg::OP_PUSH, 32'sh5);
      send_item(brsp_pkg::OP_POP,  32'sh0);

      // limit two: third copy refused
      write_limit(2);
      send_item(brsp_pkg::OP_PUSH, 32'sh55555555);
      send_item(brsp_pkg::OP_PUSH, 32'sh55555555);
      send_item(brsp_pkg::OP_PUSH, 32'sh55555555);
      send_item(brsp_pkg::OP_PUSH, 32'shAAAAAAAA);
      send_item(brsp_pkg::OP_POP,  32'sh0);
      send_item(brsp_pkg::OP_POP,  32'sh0);
      send_item(brsp_pkg::OP_POP,  32'sh0);

      // --- random phases ---
      run_phase(1, 8, 60, 100);
      run_phase(0, 8, 60, 60);
      run_phase(127, 4, 85, 110);           // limit above depth: only fullness stops
      idle_enabled = 1'b0;
      run_phase(64, 2, 80, 110);            // long scans, no idling on either side
      idle_enabled = 1'b1;
      run_phase(1, 96, 90, 120);            // fills with distinct values: full vs. rejected
      run_phase(3, 6, 70, 100);
      run_phase($urandom_range(5, 2), 16, 55, 100);

      // drain and let any stray result show up
      req_valid <= 1'b0;
      while (tracker.outstanding() != 0) @(posedge clock);
      repeat (STACK_DEPTH + 8) @(posedge clock);

      $display("Sent %0d items over %0d repeat-limit settings, zero through 127.",
               items_sent, settings_tried);
      $display("Results: pushed %0d, rejected %0d, full %0d, popped %0d, empty %0d.",
               tracker.tally[brsp_pkg::STATUS_PUSHED],
               tracker.tally[brsp_pkg::STATUS_REJECTED],
               tracker.tally[brsp_pkg::STATUS_FULL],
               tracker.tally[brsp_pkg::STATUS_POPPED],
               tracker.tally[brsp_pkg::STATUS_EMPTY]);
      if (tracker.mismatches > 10)
         $display("%0d mismatches in total", tracker.mismatches);
      if (tracker.mismatches == 0 && csr_mismatches == 0 &&
          tracker.outstanding() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
